### hdl/dsst_pkg.sv
// ----------------------------------------------------------------------------
// dsst_pkg: shared types and codes of the depth sorted stroke table
// Item and result layouts, command and status codes, and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package dsst_pkg;

    localparam int KEY_W = 16;
    localparam int TAG_W = 16;

    localparam logic [1:0] CMD_POINT = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [2:0] ST_TAKEN    = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_READ_OK  = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;
    localparam logic [2:0] ST_CLEARED  = 3'd5;

    typedef struct packed {
        logic [1:0]              command;
        logic signed [KEY_W-1:0] point_z;
        logic                    last_point;
        logic [TAG_W-1:0]        stroke_tag;
        logic [5:0]              read_index;
    } t_in_item;

    typedef struct packed {
        logic [2:0]              status;
        logic [6:0]              entry_count;
        logic [TAG_W-1:0]        read_tag;
        logic signed [KEY_W-1:0] read_key;
        logic                    point_overflow;
    } t_out_item;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } t_entry;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_TAKE,
        OP_ACC,
        OP_DIV_GO,
        OP_INS_SETUP,
        OP_INS_RD,
        OP_INS_CMP,
        OP_READ,
        OP_READ_DONE,
        OP_CLEAR,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] item_cmd;
        logic       is_last;
        logic       div_done;
        logic       table_full;
        logic       pos_zero;
        logic       shift_up;
        logic       out_free;
    } t_dp_sts;

endpackage

### hdl/dsst_if.sv
// ----------------------------------------------------------------------------
// dsst_item_if / dsst_result_if: valid/ready channels of the stroke table
// One channel carries command items in, the other carries result items out.
// ----------------------------------------------------------------------------
interface dsst_item_if import dsst_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface dsst_result_if import dsst_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hdl/dsst_div.sv
// ----------------------------------------------------------------------------
// dsst_div: serial floor divider
// Restoring divide of a signed sum by an unsigned count, one quotient bit a
// cycle, result rounded toward negative infinity and cut to key width.
// ----------------------------------------------------------------------------
module dsst_div import dsst_pkg::*; #(
    parameter int DIVIDEND_W = 27,
    parameter int DIVISOR_W  = 11
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]         i_divisor,
    output logic                         o_done,
    output logic signed [KEY_W-1:0]      o_key
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic [STEP_W-1:0]     r_step;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_den;
    logic                  r_neg;

    logic [DIVIDEND_W-1:0] mag;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;
    logic [DIVIDEND_W-1:0] q_full;

    assign mag   = i_dividend[DIVIDEND_W-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    assign o_done = r_busy && (r_step == '0);

    // negative: -(q) - 1 is ~q, add one back when the remainder is zero
    assign q_full = r_neg ? (~r_quo + DIVIDEND_W'(r_rem == '0)) : r_quo;
    assign o_key  = q_full[KEY_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= STEP_W'(DIVIDEND_W);
        end else if (r_busy) begin
            if (r_step == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= mag;
            r_rem <= '0;
            r_den <= i_divisor;
            r_neg <= i_dividend[DIVIDEND_W-1];
        end else if (r_busy && (r_step != '0)) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], fits};
            if (fits) begin
                r_rem <= DIVISOR_W'(trial - {1'b0, r_den});
            end else begin
                r_rem <= trial[DIVISOR_W-1:0];
            end
        end
    end

endmodule

### hdl/dsst_dp.sv
// ----------------------------------------------------------------------------
// dsst_dp: stroke table datapath
// Holds the item, the depth accumulator, the sorted entry memory, the
// insertion pointer and the result register; acts on controller commands.
// ----------------------------------------------------------------------------
module dsst_dp import dsst_pkg::*; #(
    parameter int TABLE_DEPTH = 64,
    parameter int MAX_POINTS  = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    input  t_in_item  i_payload,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_payload
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int SUM_W  = CNT_W + KEY_W;
    localparam int IDX_W  = (FILL_W > 6) ? FILL_W : 6;

    t_entry mem [TABLE_DEPTH];

    t_in_item                r_item;
    logic signed [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_over;
    logic [FILL_W-1:0]       r_fill;
    logic [ADDR_W-1:0]       r_pos;
    logic signed [KEY_W-1:0] r_key;
    logic [2:0]              r_status;
    logic [TAG_W-1:0]        r_rtag;
    logic signed [KEY_W-1:0] r_rkey;
    logic                    r_ovf;
    t_entry                  r_rdata;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic                    can_add;
    logic [SUM_W-1:0]        sum_add;
    logic                    table_full;
    logic                    pos_zero;
    logic                    shift_up;
    logic [IDX_W-1:0]        idx_ext;
    logic                    idx_ok;
    logic                    div_done;
    logic signed [KEY_W-1:0] div_key;
    logic                    w_en;
    logic [ADDR_W-1:0]       w_addr;
    t_entry                  w_data;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;

    assign can_add    = r_cnt < CNT_W'(MAX_POINTS);
    assign sum_add    = r_sum + {{(SUM_W-KEY_W){r_item.point_z[KEY_W-1]}}, r_item.point_z};
    assign table_full = r_fill >= FILL_W'(TABLE_DEPTH);
    assign pos_zero   = r_pos == '0;
    assign shift_up   = r_rdata.key > r_key;
    assign idx_ext    = IDX_W'(r_item.read_index);
    assign idx_ok     = idx_ext < IDX_W'(r_fill);

    dsst_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == OP_DIV_GO),
        .i_dividend (r_sum),
        .i_divisor  (r_cnt),
        .o_done     (div_done),
        .o_key      (div_key)
    );

    always_comb begin
        o_sts.item_cmd   = r_item.command;
        o_sts.is_last    = r_item.last_point;
        o_sts.div_done   = div_done;
        o_sts.table_full = table_full;
        o_sts.pos_zero   = pos_zero;
        o_sts.shift_up   = shift_up;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    // memory port control: insertion walks down from the fill point
    always_comb begin
        w_en    = 1'b0;
        w_addr  = r_pos;
        w_data  = '{key: r_key, tag: r_item.stroke_tag};
        rd_en   = 1'b0;
        rd_addr = r_pos - 1'b1;
        unique case (i_cmd.op)
            OP_INS_RD: begin
                if (pos_zero) begin
                    w_en = 1'b1;
                end else begin
                    rd_en = 1'b1;
                end
            end
            OP_INS_CMP: begin
                w_en = 1'b1;
                if (shift_up) begin
                    w_data = r_rdata;
                end
            end
            OP_READ: begin
                rd_en   = 1'b1;
                rd_addr = idx_ext[ADDR_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_cnt       <= '0;
            r_over      <= 1'b0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                OP_ACC: begin
                    if (can_add) begin
                        r_sum <= sum_add;
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_over <= 1'b1;
                    end
                end
                OP_DIV_GO: begin
                    // divider holds its operands; start the next stroke
                    r_sum  <= '0;
                    r_cnt  <= '0;
                    r_over <= 1'b0;
                end
                OP_INS_RD: begin
                    if (pos_zero) begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
                OP_INS_CMP: begin
                    if (!shift_up) begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
                OP_CLEAR: begin
                    r_fill <= '0;
                end
                default: begin
                end
            endcase
            if (i_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_TAKE: begin
                r_item   <= i_payload;
                r_status <= ST_EMPTY;
                r_rtag   <= '0;
                r_rkey   <= '0;
                r_ovf    <= 1'b0;
            end
            OP_ACC: begin
                r_status <= ST_TAKEN;
                r_ovf    <= r_over || !can_add;
            end
            OP_INS_SETUP: begin
                r_key <= div_key;
                r_pos <= r_fill[ADDR_W-1:0];
                if (table_full) begin
                    r_status <= ST_FULL;
                end
            end
            OP_INS_RD: begin
                if (pos_zero) begin
                    r_status <= ST_INSERTED;
                end
            end
            OP_INS_CMP: begin
                if (shift_up) begin
                    r_pos <= r_pos - 1'b1;
                end else begin
                    r_status <= ST_INSERTED;
                end
            end
            OP_READ: begin
                if (idx_ok) begin
                    r_status <= ST_READ_OK;
                end
            end
            OP_READ_DONE: begin
                if (r_status == ST_READ_OK) begin
                    r_rtag <= r_rdata.tag;
                    r_rkey <= r_rdata.key;
                end
            end
            OP_CLEAR: begin
                r_status <= ST_CLEARED;
            end
            OP_EMIT: begin
                r_out.status         <= r_status;
                r_out.entry_count    <= 7'(r_fill);
                r_out.read_tag       <= r_rtag;
                r_out.read_key       <= r_rkey;
                r_out.point_overflow <= r_ovf;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_payload = r_out;

endmodule

### hdl/dsst_ctrl.sv
// ----------------------------------------------------------------------------
// dsst_ctrl: stroke table controller
// Sequences one item at a time: accumulate, divide, shifted insert, read,
// clear, and hands each result to the output register.
// ----------------------------------------------------------------------------
module dsst_ctrl import dsst_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_item_valid,
    output logic    o_item_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV_GO,
        S_DIV_WAIT,
        S_INS_RD,
        S_INS_CMP,
        S_RDATA,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_item_ready = r_state == S_IDLE;

    always_comb begin
        o_cmd.op = OP_NONE;
        n_state  = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    o_cmd.op = OP_TAKE;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_sts.item_cmd)
                    CMD_POINT: begin
                        o_cmd.op = OP_ACC;
                        n_state  = i_sts.is_last ? S_DIV_GO : S_EMIT;
                    end
                    CMD_READ: begin
                        o_cmd.op = OP_READ;
                        n_state  = S_RDATA;
                    end
                    CMD_CLEAR: begin
                        o_cmd.op = OP_CLEAR;
                        n_state  = S_EMIT;
                    end
                    default: begin
                        // unused code: answer index empty, change nothing
                        n_state = S_EMIT;
                    end
                endcase
            end
            S_DIV_GO: begin
                o_cmd.op = OP_DIV_GO;
                n_state  = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.op = OP_INS_SETUP;
                    n_state  = i_sts.table_full ? S_EMIT : S_INS_RD;
                end
            end
            S_INS_RD: begin
                o_cmd.op = OP_INS_RD;
                n_state  = i_sts.pos_zero ? S_EMIT : S_INS_CMP;
            end
            S_INS_CMP: begin
                o_cmd.op = OP_INS_CMP;
                n_state  = i_sts.shift_up ? S_INS_RD : S_EMIT;
            end
            S_RDATA: begin
                o_cmd.op = OP_READ_DONE;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                // hold until the output register can take the result
                if (i_sts.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hdl/depth_sorted_stroke_table_unit.sv
// ----------------------------------------------------------------------------
// depth_sorted_stroke_table_unit: depth sorted stroke table
// Sums stroke point depths, forms a floor average key on the last point and
// keeps stroke tags in a table sorted by ascending key.
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries commands (point, read, clear); o_result returns exactly
//   one result per command, in order, through a registered output stage.
//   Items are handled one at a time. A read adds one registered memory
//   read. A last point adds the serial divider, one quotient bit a cycle,
//   then the insert, which walks the entry memory down from the fill point,
//   reading then writing each entry moved (one read, one write port) until
//   it reaches its place or position zero. The next item is accepted the
//   cycle after its result enters the output register.
//   While the receiver stalls, a finished result waits in the output stage
//   and the next item is still accepted and worked on; it then holds until
//   the output stage frees up.
//   Reset empties the table and the running stroke. Entry memory is not
//   cleared; only entries below the fill count are ever used.
// ----------------------------------------------------------------------------
module depth_sorted_stroke_table_unit import dsst_pkg::*; #(
    parameter int TABLE_DEPTH = 64,
    parameter int MAX_POINTS  = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    dsst_item_if.sink            i_item,
    dsst_result_if.source        o_result
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    item_ready;

    assign i_item.ready = item_ready;

    dsst_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .o_item_ready (item_ready),
        .i_sts        (dp_sts),
        .o_cmd        (dp_cmd)
    );

    dsst_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_POINTS  (MAX_POINTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_payload     (i_item.payload),
        .o_out_valid   (o_result.valid),
        .i_out_ready   (o_result.ready),
        .o_out_payload (o_result.payload)
    );

    // one item in flight: no second accept right after one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && item_ready) |=> !item_ready)
        else $error("item accepted while another is in flight");

    // a result only enters the output stage when that stage is free
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.op == OP_EMIT) |-> dp_sts.out_free)
        else $error("result overwrote a waiting result");

    // compare step must see the memory data read in the cycle before
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.op == OP_INS_CMP) |-> ($past(dp_cmd.op) == OP_INS_RD))
        else $error("insert compare without a preceding read");

endmodule
